// ===== src/i2crm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types and constants of the I2C register master: request and
// result payloads, request modes and bus phases.
// ----------------------------------------------------------------------------
`default_nettype none

package i2crm_pkg;

	// Default number of bytes in a burst read
	localparam int BURST_LENGTH_DEF = 8;

	// Request modes
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_READ  = 2'd2,
		MODE_BURST = 2'd3
	} mode_t;

	// Bus phases
	typedef enum logic [4:0] {
		PH_IDLE      = 5'd0,
		PH_START1    = 5'd1,
		PH_ADDRW     = 5'd2,
		PH_ACK_ADDRW = 5'd3,
		PH_CMD       = 5'd4,
		PH_ACK_CMD   = 5'd5,
		PH_DATA      = 5'd6,
		PH_ACK_DATA  = 5'd7,
		PH_START2    = 5'd8,
		PH_ADDRR     = 5'd9,
		PH_ACK_ADDRR = 5'd10,
		PH_RECV      = 5'd11,
		PH_MACK      = 5'd12,
		PH_STOP      = 5'd13
	} phase_t;

	// One request item (one bus tick)
	typedef struct packed {
		mode_t      mode;
		logic [7:0] command_byte;
		logic [7:0] write_data;
		logic       sda_in;
	} req_item_t;

	// One result item
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       byte_valid;
		logic [7:0] read_byte;
		logic       done_res;
		logic       nack_seen;
	} rsp_item_t;

endpackage

`default_nettype wire

// ===== src/i2crm_if.sv =====
// ----------------------------------------------------------------------------
// i2crm_if
// Valid/ready channels of the I2C register master: request and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2crm_req_if;
	logic             valid;
	logic             ready;
	i2crm_pkg::mode_t mode;
	logic [7:0]       command_byte;
	logic [7:0]       write_data;
	logic             sda_in;

	modport source (output valid, output mode, output command_byte,
		output write_data, output sda_in, input ready);
	modport sink (input valid, input mode, input command_byte,
		input write_data, input sda_in, output ready);
endinterface

interface i2crm_rsp_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       byte_valid;
	logic [7:0] read_byte;
	logic       done_res;
	logic       nack_seen;

	modport source (output valid, output scl_out, output sda_out, output busy_res,
		output byte_valid, output read_byte, output done_res, output nack_seen,
		input ready);
	modport sink (input valid, input scl_out, input sda_out, input busy_res,
		input byte_valid, input read_byte, input done_res, input nack_seen,
		output ready);
endinterface

`default_nettype wire

// ===== src/i2crm_in_reg.sv =====
// ----------------------------------------------------------------------------
// i2crm_in_reg
// Input register: captures one request transfer, releases it when the
// engine consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crm_in_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	i2crm_req_if.sink              request,
	input  wire logic              advance,
	output logic                   valid_s1,
	output i2crm_pkg::req_item_t   item_s1
);

	// Accept when empty or when the held item moves on this cycle
	assign request.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			item_s1.mode         <= request.mode;
			item_s1.command_byte <= request.command_byte;
			item_s1.write_data   <= request.write_data;
			item_s1.sda_in       <= request.sda_in;
		end
	end

endmodule

`default_nettype wire

// ===== src/i2crm_engine.sv =====
// ----------------------------------------------------------------------------
// i2crm_engine
// Bus sequencer: one pin action per consumed tick. Holds the phase, bit
// position, shift byte and pin levels; computes the result of the tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crm_engine #(
	parameter int BURST_LENGTH = i2crm_pkg::BURST_LENGTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step_en,
	input  wire i2crm_pkg::req_item_t item,
	input  wire logic [6:0]           device_address,
	output i2crm_pkg::rsp_item_t      result
);

	localparam int CNT_W = (BURST_LENGTH > 1) ? $clog2(BURST_LENGTH) : 1;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BURST_LENGTH - 1);

	i2crm_pkg::phase_t phase_q, phase_d;
	i2crm_pkg::mode_t  kind_q, kind_d;
	logic [1:0]        step_q, step_d;
	logic [2:0]        bit_q, bit_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [7:0]        shift_q, shift_d;
	logic [7:0]        cmd_q, cmd_d;
	logic [7:0]        data_q, data_d;
	logic              nack_q, nack_d;
	logic              scl_q, scl_d;
	logic              sda_q, sda_d;
	logic              byte_vld;
	logic [7:0]        byte_val;
	logic              done;
	logic              nack_rep;
	logic [7:0]        addr_w;
	logic [7:0]        addr_r;

	assign addr_w = {device_address, 1'b0};
	assign addr_r = {device_address, 1'b1};

	// Next state and pin action for this tick
	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		step_d   = step_q;
		bit_d    = bit_q;
		cnt_d    = cnt_q;
		shift_d  = shift_q;
		cmd_d    = cmd_q;
		data_d   = data_q;
		nack_d   = nack_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		byte_vld = 1'b0;
		byte_val = 8'h00;
		done     = 1'b0;
		nack_rep = 1'b0;

		// New request, only when idle; acts on this same tick
		if (phase_q == i2crm_pkg::PH_IDLE && item.mode != i2crm_pkg::MODE_TICK) begin
			kind_d  = item.mode;
			cmd_d   = item.command_byte;
			data_d  = item.write_data;
			nack_d  = 1'b0;
			cnt_d   = '0;
			bit_d   = 3'd0;
			step_d  = 2'd0;
			phase_d = i2crm_pkg::PH_START1;
		end

		unique case (phase_d)
			i2crm_pkg::PH_IDLE: begin
				scl_d = 1'b1;
				sda_d = 1'b1;
			end
			// start and repeated start
			i2crm_pkg::PH_START1, i2crm_pkg::PH_START2: begin
				unique case (step_d)
					2'd0: begin
						sda_d  = 1'b1;
						step_d = 2'd1;
					end
					2'd1: begin
						scl_d  = 1'b1;
						step_d = 2'd2;
					end
					2'd2: begin
						sda_d  = 1'b0;
						step_d = 2'd3;
					end
					default: begin
						scl_d  = 1'b0;
						bit_d  = 3'd0;
						step_d = 2'd0;
						if (phase_d == i2crm_pkg::PH_START1) begin
							shift_d = addr_w;
							phase_d = i2crm_pkg::PH_ADDRW;
						end else begin
							shift_d = addr_r;
							phase_d = i2crm_pkg::PH_ADDRR;
						end
					end
				endcase
			end
			// master sends a byte, MSB first
			i2crm_pkg::PH_ADDRW, i2crm_pkg::PH_CMD, i2crm_pkg::PH_DATA,
			i2crm_pkg::PH_ADDRR: begin
				unique case (step_d)
					2'd0: begin
						sda_d  = shift_d[7];
						step_d = 2'd1;
					end
					2'd1: begin
						scl_d  = 1'b1;
						step_d = 2'd2;
					end
					default: begin
						scl_d   = 1'b0;
						shift_d = {shift_d[6:0], 1'b0};
						step_d  = 2'd0;
						if (bit_d == 3'd7) begin
							bit_d = 3'd0;
							unique case (phase_d)
								i2crm_pkg::PH_ADDRW: phase_d = i2crm_pkg::PH_ACK_ADDRW;
								i2crm_pkg::PH_CMD:   phase_d = i2crm_pkg::PH_ACK_CMD;
								i2crm_pkg::PH_DATA:  phase_d = i2crm_pkg::PH_ACK_DATA;
								default:             phase_d = i2crm_pkg::PH_ACK_ADDRR;
							endcase
						end else begin
							bit_d = bit_d + 3'd1;
						end
					end
				endcase
			end
			// slave ack, sampled into the sticky flag
			i2crm_pkg::PH_ACK_ADDRW, i2crm_pkg::PH_ACK_CMD, i2crm_pkg::PH_ACK_DATA,
			i2crm_pkg::PH_ACK_ADDRR: begin
				unique case (step_d)
					2'd0: begin
						sda_d  = 1'b1;
						step_d = 2'd1;
					end
					2'd1: begin
						scl_d  = 1'b1;
						step_d = 2'd2;
					end
					2'd2: begin
						nack_d = nack_d | item.sda_in;
						step_d = 2'd3;
					end
					default: begin
						scl_d  = 1'b0;
						step_d = 2'd0;
						unique case (phase_d)
							i2crm_pkg::PH_ACK_ADDRW: begin
								shift_d = cmd_d;
								bit_d   = 3'd0;
								phase_d = i2crm_pkg::PH_CMD;
							end
							i2crm_pkg::PH_ACK_CMD: begin
								if (kind_d == i2crm_pkg::MODE_WRITE) begin
									shift_d = data_d;
									bit_d   = 3'd0;
									phase_d = i2crm_pkg::PH_DATA;
								end else begin
									phase_d = i2crm_pkg::PH_START2;
								end
							end
							i2crm_pkg::PH_ACK_DATA: begin
								phase_d = i2crm_pkg::PH_STOP;
							end
							default: begin
								cnt_d   = '0;
								shift_d = 8'h00;
								bit_d   = 3'd0;
								phase_d = i2crm_pkg::PH_RECV;
							end
						endcase
					end
				endcase
			end
			// receive a byte, MSB first
			i2crm_pkg::PH_RECV: begin
				unique case (step_d)
					2'd0: begin
						sda_d  = 1'b1;
						step_d = 2'd1;
					end
					2'd1: begin
						scl_d  = 1'b1;
						step_d = 2'd2;
					end
					2'd2: begin
						shift_d = {shift_d[6:0], item.sda_in};
						step_d  = 2'd3;
					end
					default: begin
						scl_d = 1'b0;
						if (bit_d == 3'd7) begin
							byte_vld = 1'b1;
							byte_val = shift_d;
							bit_d    = 3'd0;
							step_d   = 2'd0;
							phase_d  = i2crm_pkg::PH_MACK;
						end else begin
							bit_d  = bit_d + 3'd1;
							step_d = 2'd1;
						end
					end
				endcase
			end
			// master ack: low in a burst, high (NACK) otherwise
			i2crm_pkg::PH_MACK: begin
				unique case (step_d)
					2'd0: begin
						sda_d  = (kind_d == i2crm_pkg::MODE_BURST) ? 1'b0 : 1'b1;
						step_d = 2'd1;
					end
					2'd1: begin
						scl_d  = 1'b1;
						step_d = 2'd2;
					end
					default: begin
						scl_d  = 1'b0;
						step_d = 2'd0;
						if (kind_d == i2crm_pkg::MODE_BURST && cnt_d < LAST_CNT) begin
							cnt_d   = cnt_d + CNT_W'(1);
							shift_d = 8'h00;
							bit_d   = 3'd0;
							phase_d = i2crm_pkg::PH_RECV;
						end else begin
							phase_d = i2crm_pkg::PH_STOP;
						end
					end
				endcase
			end
			// stop condition
			i2crm_pkg::PH_STOP: begin
				unique case (step_d)
					2'd0: begin
						sda_d  = 1'b0;
						step_d = 2'd1;
					end
					2'd1: begin
						scl_d  = 1'b1;
						step_d = 2'd2;
					end
					default: begin
						sda_d    = 1'b1;
						done     = 1'b1;
						nack_rep = nack_d;
						phase_d  = i2crm_pkg::PH_IDLE;
						step_d   = 2'd0;
						bit_d    = 3'd0;
						cnt_d    = '0;
					end
				endcase
			end
			// unused phase codes recover to idle
			default: begin
				phase_d = i2crm_pkg::PH_IDLE;
				step_d  = 2'd0;
				bit_d   = 3'd0;
				cnt_d   = '0;
				scl_d   = 1'b1;
				sda_d   = 1'b1;
			end
		endcase
	end

	// Result of this tick
	always_comb begin
		result.scl_out    = scl_d;
		result.sda_out    = sda_d;
		result.busy_res   = (phase_d != i2crm_pkg::PH_IDLE);
		result.byte_valid = byte_vld;
		result.read_byte  = byte_val;
		result.done_res   = done;
		result.nack_seen  = nack_rep;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2crm_pkg::PH_IDLE;
			kind_q  <= i2crm_pkg::MODE_TICK;
			step_q  <= 2'd0;
			bit_q   <= 3'd0;
			cnt_q   <= '0;
			shift_q <= 8'h00;
			cmd_q   <= 8'h00;
			data_q  <= 8'h00;
			nack_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (step_en) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			step_q  <= step_d;
			bit_q   <= bit_d;
			cnt_q   <= cnt_d;
			shift_q <= shift_d;
			cmd_q   <= cmd_d;
			data_q  <= data_d;
			nack_q  <= nack_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/i2crm_out_reg.sv =====
// ----------------------------------------------------------------------------
// i2crm_out_reg
// Result register: holds one result until the downstream transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crm_out_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire i2crm_pkg::rsp_item_t result,
	output logic                      space,
	i2crm_rsp_if.source               rsp
);

	logic                 valid_q;
	i2crm_pkg::rsp_item_t data_q;

	// Room for a new result when empty or draining this cycle
	assign space = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.scl_out    = data_q.scl_out;
	assign rsp.sda_out    = data_q.sda_out;
	assign rsp.busy_res   = data_q.busy_res;
	assign rsp.byte_valid = data_q.byte_valid;
	assign rsp.read_byte  = data_q.read_byte;
	assign rsp.done_res   = data_q.done_res;
	assign rsp.nack_seen  = data_q.nack_seen;

endmodule

`default_nettype wire

// ===== src/i2c_register_master_core.sv =====
// ----------------------------------------------------------------------------
// i2c_register_master_core
// I2C master that drives SCL/SDA itself: register write, register read and
// burst read, one pin action per request tick.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  request   in   valid/ready      mode, command_byte, write_data, sda_in
//  result    out  valid/ready      scl_out, sda_out, busy_res, byte_valid,
//                                  read_byte, done_res, nack_seen
//  cfg       in   cfg_we           cfg_wdata (device address, 7 bits)
//
//  One tick per clock while the result side takes results; a tick passes the
//  input register, then the sequencer logic into the result register.
//  Reset leaves the bus idle with both pins released.
//  A stalled result holds the result register; the input register takes one
//  more tick only if it was empty, then ready drops until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_master_core #(
	parameter int BURST_LENGTH = i2crm_pkg::BURST_LENGTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	i2crm_req_if.sink       request,
	i2crm_rsp_if.source     result,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_wdata
);

	logic                 valid_s1;
	i2crm_pkg::req_item_t item_s1;
	i2crm_pkg::rsp_item_t step_res;
	logic                 space;
	logic                 advance;
	logic [6:0]           dev_addr_q;

	// Device address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= 7'd0;
		end else if (cfg_we) begin
			dev_addr_q <= cfg_wdata;
		end
	end

	// A tick is consumed when the result register has room
	assign advance = valid_s1 && space;

	i2crm_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	i2crm_engine #(
		.BURST_LENGTH (BURST_LENGTH)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (advance),
		.item           (item_s1),
		.device_address (dev_addr_q),
		.result         (step_res)
	);

	i2crm_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.result (step_res),
		.space  (space),
		.rsp    (result)
	);

endmodule

`default_nettype wire

// ===== dv/i2crm_bus_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_bus_checker
// Watches the request, result and address-write ports of the I2C register
// master. Each accepted tick is run through a local model of the pin
// sequencer. The pin levels, byte and status it gives are queued, and every
// accepted result is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------

module i2crm_bus_checker
	import i2crm_pkg::*;
#(
	parameter int BURST_LEN = BURST_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	i2crm_req_if       req_mon,
	i2crm_rsp_if       rsp_mon,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	output int         errors,
	output int         outstanding,
	output logic       seq_idle
);

	// Model state of the sequencer
	logic [6:0] dev_addr;
	phase_t     ph;
	mode_t      kind;
	logic [1:0] step;
	logic [2:0] bidx;
	logic [6:0] bcount;
	logic [7:0] shreg;
	logic [7:0] held_cmd;
	logic [7:0] held_dat;
	logic       nack;
	logic       pin_scl;
	logic       pin_sda;

	rsp_item_t  planned_pins[$];
	rsp_item_t  got;
	rsp_item_t  want;
	req_item_t  tick;
	int         fail_count = 0;
	int         queued = 0;
	logic       idle_now = 1'b1;
	int         results_seen;

	assign errors      = fail_count;
	assign outstanding = queued;
	assign seq_idle    = idle_now;

	task automatic report(input string msg);
		$display("checker: %s", msg);
		fail_count++;
	endtask

	task automatic load_send(input logic [7:0] value, input phase_t next_ph);
		shreg = value;
		bidx  = '0;
		step  = '0;
		ph    = next_ph;
	endtask

	task automatic begin_receive();
		shreg = '0;
		bidx  = '0;
		step  = '0;
		ph    = PH_RECV;
	endtask

	// One bus tick of the sequencer: pin action, state update, result
	task automatic advance_bus(input req_item_t it, output rsp_item_t r);
		logic [7:0] addr_w;
		logic [7:0] addr_r;
		addr_w = {dev_addr, 1'b0};
		addr_r = {dev_addr, 1'b1};
		r = '0;

		// request taken only in idle, otherwise a plain tick
		if (ph == PH_IDLE && it.mode != MODE_TICK) begin
			kind     = it.mode;
			held_cmd = it.command_byte;
			held_dat = it.write_data;
			nack     = 1'b0;
			bcount   = '0;
			bidx     = '0;
			step     = '0;
			ph       = PH_START1;
		end

		case (ph)
			PH_IDLE: begin
				pin_scl = 1'b1;
				pin_sda = 1'b1;
			end
			// start and repeated start
			PH_START1, PH_START2: begin
				case (step)
					2'd0: begin pin_sda = 1'b1; step = 2'd1; end
					2'd1: begin pin_scl = 1'b1; step = 2'd2; end
					2'd2: begin pin_sda = 1'b0; step = 2'd3; end
					default: begin
						pin_scl = 1'b0;
						if (ph == PH_START1)
							load_send(addr_w, PH_ADDRW);
						else
							load_send(addr_r, PH_ADDRR);
					end
				endcase
			end
			// byte out, MSB first
			PH_ADDRW, PH_CMD, PH_DATA, PH_ADDRR: begin
				case (step)
					2'd0: begin pin_sda = shreg[7]; step = 2'd1; end
					2'd1: begin pin_scl = 1'b1; step = 2'd2; end
					default: begin
						pin_scl = 1'b0;
						shreg   = {shreg[6:0], 1'b0};
						step    = '0;
						if (bidx == 3'd7) begin
							bidx = '0;
							ph   = phase_t'(ph + 5'd1);
						end else begin
							bidx = bidx + 3'd1;
						end
					end
				endcase
			end
			// slave ack slot, sample ORed into the sticky flag
			PH_ACK_ADDRW, PH_ACK_CMD, PH_ACK_DATA, PH_ACK_ADDRR: begin
				case (step)
					2'd0: begin pin_sda = 1'b1; step = 2'd1; end
					2'd1: begin pin_scl = 1'b1; step = 2'd2; end
					2'd2: begin nack = nack | it.sda_in; step = 2'd3; end
					default: begin
						pin_scl = 1'b0;
						step    = '0;
						case (ph)
							PH_ACK_ADDRW: load_send(held_cmd, PH_CMD);
							PH_ACK_CMD: begin
								if (kind == MODE_WRITE)
									load_send(held_dat, PH_DATA);
								else
									ph = PH_START2;
							end
							PH_ACK_DATA: ph = PH_STOP;
							default: begin
								bcount = '0;
								begin_receive();
							end
						endcase
					end
				endcase
			end
			// byte in, SDA released
			PH_RECV: begin
				case (step)
					2'd0: begin pin_sda = 1'b1; step = 2'd1; end
					2'd1: begin pin_scl = 1'b1; step = 2'd2; end
					2'd2: begin shreg = {shreg[6:0], it.sda_in}; step = 2'd3; end
					default: begin
						pin_scl = 1'b0;
						if (bidx == 3'd7) begin
							r.byte_valid = 1'b1;
							r.read_byte  = shreg;
							bidx = '0;
							step = '0;
							ph   = PH_MACK;
						end else begin
							bidx = bidx + 3'd1;
							step = 2'd1;
						end
					end
				endcase
			end
			// master ack: low in a burst, NACK on a single read
			PH_MACK: begin
				case (step)
					2'd0: begin pin_sda = (kind == MODE_BURST) ? 1'b0 : 1'b1; step = 2'd1; end
					2'd1: begin pin_scl = 1'b1; step = 2'd2; end
					default: begin
						pin_scl = 1'b0;
						step    = '0;
						if (kind == MODE_BURST && int'(bcount) + 1 < BURST_LEN) begin
							bcount = bcount + 7'd1;
							begin_receive();
						end else begin
							ph = PH_STOP;
						end
					end
				endcase
			end
			PH_STOP: begin
				case (step)
					2'd0: begin pin_sda = 1'b0; step = 2'd1; end
					2'd1: begin pin_scl = 1'b1; step = 2'd2; end
					default: begin
						pin_sda     = 1'b1;
						r.done_res  = 1'b1;
						r.nack_seen = nack;
						ph     = PH_IDLE;
						step   = '0;
						bidx   = '0;
						bcount = '0;
					end
				endcase
			end
			default: begin
				ph      = PH_IDLE;
				step    = '0;
				bidx    = '0;
				bcount  = '0;
				pin_scl = 1'b1;
				pin_sda = 1'b1;
			end
		endcase

		r.scl_out  = pin_scl;
		r.sda_out  = pin_sda;
		r.busy_res = (ph != PH_IDLE);
	endtask

	// Monitor: address writes, result transfers, request transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr = '0;
			ph       = PH_IDLE;
			kind     = MODE_TICK;
			step     = '0;
			bidx     = '0;
			bcount   = '0;
			shreg    = '0;
			held_cmd = '0;
			held_dat = '0;
			nack     = 1'b0;
			pin_scl  = 1'b1;
			pin_sda  = 1'b1;
			results_seen = 0;
			planned_pins.delete();
			queued   <= 0;
			idle_now <= 1'b1;
		end else begin
			if (cfg_we)
				dev_addr = cfg_wdata;

			if (rsp_mon.valid && rsp_mon.ready) begin
				got.scl_out    = rsp_mon.scl_out;
				got.sda_out    = rsp_mon.sda_out;
				got.busy_res   = rsp_mon.busy_res;
				got.byte_valid = rsp_mon.byte_valid;
				got.read_byte  = rsp_mon.read_byte;
				got.done_res   = rsp_mon.done_res;
				got.nack_seen  = rsp_mon.nack_seen;
				if (planned_pins.size() == 0) begin
					report($sformatf("transfer %0d: result with nothing pending", results_seen));
				end else begin
					want = planned_pins.pop_front();
					if (got.scl_out !== want.scl_out)
						report($sformatf("transfer %0d: scl_out expected %0b got %0b",
							results_seen, want.scl_out, got.scl_out));
					if (got.sda_out !== want.sda_out)
						report($sformatf("transfer %0d: sda_out expected %0b got %0b",
							results_seen, want.sda_out, got.sda_out));
					if (got.busy_res !== want.busy_res)
						report($sformatf("transfer %0d: busy_res expected %0b got %0b",
							results_seen, want.busy_res, got.busy_res));
					if (got.byte_valid !== want.byte_valid)
						report($sformatf("transfer %0d: byte_valid expected %0b got %0b",
							results_seen, want.byte_valid, got.byte_valid));
					if (got.read_byte !== want.read_byte)
						report($sformatf("transfer %0d: read_byte expected %02h got %02h",
							results_seen, want.read_byte, got.read_byte));
					if (got.done_res !== want.done_res)
						report($sformatf("transfer %0d: done_res expected %0b got %0b",
							results_seen, want.done_res, got.done_res));
					if (got.nack_seen !== want.nack_seen)
						report($sformatf("transfer %0d: nack_seen expected %0b got %0b",
							results_seen, want.nack_seen, got.nack_seen));
				end
				results_seen++;
			end

			if (req_mon.valid && req_mon.ready) begin
				tick.mode         = req_mon.mode;
				tick.command_byte = req_mon.command_byte;
				tick.write_data   = req_mon.write_data;
				tick.sda_in       = req_mon.sda_in;
				advance_bus(tick, want);
				planned_pins.push_back(want);
			end

			queued   <= planned_pins.size();
			idle_now <= (ph == PH_IDLE);
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the I2C register master tick by tick: directed register writes,
// register reads and burst reads with chosen SDA styles, then random
// request/tick streams under three device addresses, with random gaps on the
// request side and random stalls on the result side. Checking is done by
// i2crm_bus_checker.
// ----------------------------------------------------------------------------

module tb_top;
	import i2crm_pkg::*;

	// How the SDA input behaves on the ticks after a request
	typedef enum int {
		SDA_NOISY,
		SDA_LOW,
		SDA_HIGH,
		SDA_MOSTLY_LOW
	} sda_style_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;
	int         errors;
	int         outstanding;
	logic       seq_idle;
	int         calm_left = 0;
	int         ticks_sent = 0;
	int         requests_sent = 0;

	i2crm_req_if req_ch();
	i2crm_rsp_if rsp_ch();

	i2c_register_master_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (req_ch),
		.result    (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	i2crm_bus_checker bus_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_mon     (req_ch),
		.rsp_mon     (rsp_ch),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.errors      (errors),
		.outstanding (outstanding),
		.seq_idle    (seq_idle)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop
	initial begin
		#6_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// Idle length: mostly none or short, rarely long, with calm stretches
	function automatic int pause_len();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 149) == 0) begin
			calm_left = $urandom_range(50, 200);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic pick_sda(input sda_style_t style);
		case (style)
			SDA_LOW:        return 1'b0;
			SDA_HIGH:       return 1'b1;
			SDA_MOSTLY_LOW: return ($urandom_range(0, 47) == 0);
			default:        return 1'(($urandom & 32'h1));
		endcase
	endfunction

	// Result side: random stalls
	initial begin
		int run;
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(1, 40);
			@(negedge clk) rsp_ch.ready <= 1'b1;
			repeat (run - 1) @(negedge clk);
			stall = pause_len();
			if (stall > 0) begin
				@(negedge clk) rsp_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// One tick transfer; valid stays high into the next call when no gap
	task automatic push_item(input req_item_t it);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			@(negedge clk) req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid        <= 1'b1;
		req_ch.mode         <= it.mode;
		req_ch.command_byte <= it.command_byte;
		req_ch.write_data   <= it.write_data;
		req_ch.sda_in       <= it.sda_in;
		do @(posedge clk); while (!req_ch.ready);
		ticks_sent++;
		if (it.mode != MODE_TICK)
			requests_sent++;
	endtask

	function automatic req_item_t plain_tick(input sda_style_t style);
		req_item_t it;
		it.mode         = MODE_TICK;
		it.command_byte = 8'($urandom);
		it.write_data   = 8'($urandom);
		it.sda_in       = pick_sda(style);
		return it;
	endfunction

	// Ticks until the sequencer is idle, then let all results drain.
	// seq_idle seen at an accept edge is the state after the previous tick.
	task automatic settle_bus();
		do push_item(plain_tick(SDA_NOISY)); while (!seq_idle);
		@(negedge clk) req_ch.valid <= 1'b0;
		wait (outstanding == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_address(input logic [6:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	// One whole transaction, optionally with a request while busy
	task automatic run_txn(input mode_t m, input logic [7:0] cmd, input logic [7:0] dat,
			input sda_style_t style, input bit busy_request);
		req_item_t it;
		int n;
		it.mode         = m;
		it.command_byte = cmd;
		it.write_data   = dat;
		it.sda_in       = pick_sda(style);
		push_item(it);
		n = 0;
		do begin
			it = plain_tick(style);
			if (busy_request && n == 12)
				it.mode = mode_t'($urandom_range(1, 3));
			push_item(it);
			n++;
		end while (!seq_idle);
	endtask

	// Random stream: mostly ticks, occasional requests (ignored when busy)
	task automatic run_random(input int count);
		req_item_t it;
		sda_style_t style;
		style = SDA_NOISY;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 21) == 0) begin
				style = sda_style_t'($urandom_range(0, 3));
				it.mode         = mode_t'($urandom_range(1, 3));
				it.command_byte = 8'($urandom);
				it.write_data   = 8'($urandom);
				it.sda_in       = pick_sda(style);
			end else begin
				it = plain_tick(style);
			end
			push_item(it);
		end
	endtask

	// Stimulus and verdict
	initial begin
		req_ch.valid        = 1'b0;
		req_ch.mode         = MODE_TICK;
		req_ch.command_byte = '0;
		req_ch.write_data   = '0;
		req_ch.sda_in       = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: highest address
		write_address(7'h7f);
		push_item(plain_tick(SDA_NOISY));
		push_item(plain_tick(SDA_HIGH));
		run_txn(MODE_WRITE, 8'hff, 8'h00, SDA_LOW, 1'b0);
		run_txn(MODE_WRITE, 8'h00, 8'hff, SDA_HIGH, 1'b1);
		run_txn(MODE_READ, 8'ha5, 8'h00, SDA_HIGH, 1'b0);
		run_txn(MODE_READ, 8'h5a, 8'hff, SDA_LOW, 1'b1);
		run_txn(MODE_BURST, 8'h3c, 8'h00, SDA_NOISY, 1'b0);
		run_txn(MODE_BURST, 8'hc3, 8'hff, SDA_MOSTLY_LOW, 1'b1);
		settle_bus();

		// Lowest address
		write_address(7'h00);
		run_txn(MODE_WRITE, 8'h80, 8'h01, SDA_LOW, 1'b0);
		run_txn(MODE_READ, 8'h01, 8'h80, SDA_NOISY, 1'b0);
		run_random(160);
		settle_bus();

		write_address(7'h55);
		run_random(160);
		settle_bus();

		write_address(7'h2a);
		run_random(160);
		settle_bus();

		$display("tb_top: %0d ticks sent, %0d of them requests (some while busy)",
			ticks_sent, requests_sent);
		$display("tb_top: writes, reads and burst reads under addresses 7f, 00, 55, 2a");
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
